@@ sv/fpba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and constants of the partition allocator
// Widths, command and policy codes, register indexes and the structs that
// pass between the top level and the scan engine.
// ----------------------------------------------------------------------------
package fpba_pkg;

  localparam int IDX_W       = 6;
  localparam int MAX_ENTRIES = 1 << IDX_W;
  localparam int CNT_W       = IDX_W + 1;
  localparam int SIZE_W      = 16;
  localparam int POL_W       = 2;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_FIT_POLICY  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_COUNT = 2'd1;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  entry_index;
    logic [SIZE_W-1:0] entry_size;
    logic [SIZE_W-1:0] request_size;
    logic              final_request;
  } fpba_req_t;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] chosen_index;
    logic             batch_end;
  } fpba_res_t;

  typedef struct packed {
    logic start;
    logic res_ready;
  } fpba_ctl_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } fpba_stat_t;

endpackage

`default_nettype wire

@@ sv/fpba_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_if: channel interfaces of the partition allocator
// Request, response and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface fpba_req_if;
  import fpba_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IDX_W-1:0]  entry_index;
  logic [SIZE_W-1:0] entry_size;
  logic [SIZE_W-1:0] request_size;
  logic              final_request;

  modport source (output valid, cmd, entry_index, entry_size, request_size,
                  final_request, input ready);
  modport sink   (input valid, cmd, entry_index, entry_size, request_size,
                  final_request, output ready);
endinterface

interface fpba_rsp_if;
  import fpba_pkg::*;
  logic             valid;
  logic             ready;
  logic             granted;
  logic [IDX_W-1:0] chosen_index;
  logic             batch_end;

  modport source (output valid, granted, chosen_index, batch_end, input ready);
  modport sink   (input valid, granted, chosen_index, batch_end, output ready);
endinterface

interface fpba_cfg_if;
  import fpba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ sv/fpba_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_scan: partition table and fit scan engine
// Holds the size memory and taken marks; walks entries one per cycle
// through a single compare unit and keeps the running best pick.
// ----------------------------------------------------------------------------
module fpba_scan (
  input  wire                      clk,
  input  wire                      rst,
  input  wire fpba_pkg::fpba_ctl_t ctl,
  input  wire fpba_pkg::fpba_req_t req,
  input  wire [fpba_pkg::POL_W-1:0] policy,
  input  wire [fpba_pkg::CNT_W-1:0] limit,
  output fpba_pkg::fpba_stat_t     stat,
  output fpba_pkg::fpba_res_t      res
);
  import fpba_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state;
  fpba_req_t              cur;
  logic [CNT_W-1:0]       rd_addr;
  logic                   rd_vld;
  logic [IDX_W-1:0]       rd_idx;
  logic [SIZE_W-1:0]      rd_data;
  logic                   rd_taken;
  logic                   found;
  logic [IDX_W-1:0]       best_idx;
  logic [SIZE_W-1:0]      best_size;
  logic [MAX_ENTRIES-1:0] taken;
  logic [SIZE_W-1:0]      mem [MAX_ENTRIES];

  logic issue;
  logic mem_we;
  logic better;
  logic take;

  assign issue  = (state == ST_SCAN) && (rd_addr < limit);
  assign mem_we = ctl.start && (req.cmd == CMD_LOAD);

  always_comb begin
    case (policy)
      POL_BEST:  better = rd_data < best_size;
      POL_WORST: better = rd_data > best_size;
      default:   better = 1'b0;   // first fit, unused code too
    endcase
  end

  assign take = rd_vld && !rd_taken && (rd_data >= cur.request_size) &&
                (!found || better);

  // size memory: one write port for loads, one registered read for the scan
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[req.entry_index] <= req.entry_size;
    end
    rd_data <= mem[rd_addr[IDX_W-1:0]];
  end

  // payload
  always_ff @(posedge clk) begin
    rd_idx   <= rd_addr[IDX_W-1:0];
    rd_taken <= taken[rd_addr[IDX_W-1:0]];  // marks are steady during a scan
    if (ctl.start) begin
      cur <= req;
    end
    if (take) begin
      best_idx  <= rd_idx;
      best_size <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_addr <= '0;
      rd_vld  <= 1'b0;
      found   <= 1'b0;
      taken   <= '0;
    end else begin
      rd_vld <= issue;
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            found   <= 1'b0;
            rd_addr <= '0;
            if (req.cmd == CMD_LOAD) begin
              taken[req.entry_index] <= 1'b0;
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (take) begin
            found <= 1'b1;
          end
          if (!issue && !rd_vld) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ctl.res_ready) begin
            if (res.granted) begin
              taken[best_idx] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res.granted      = (cur.cmd == CMD_ALLOC) && found;
    res.chosen_index = res.granted ? best_idx : '0;
    res.batch_end    = (cur.cmd == CMD_ALLOC) && cur.final_request;
    stat.idle        = (state == ST_IDLE);
    stat.res_valid   = (state == ST_DONE);
  end

endmodule

`default_nettype wire

@@ sv/fit_policy_block_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit: first / best / worst fit partition allocator
// Partition table with load and allocate beats and a one-per-cycle fit scan.
// ----------------------------------------------------------------------------
// Usage
//   req : request beats. cmd load writes entry_size to entry_index and frees
//         that entry; cmd alloc looks for a free entry of at least
//         request_size among the first entry_count entries.
//   rsp : one beat per request. granted/chosen_index report the pick,
//         batch_end echoes final_request of an alloc (0 for loads).
//   cfg : register writes, addr 0 fit_policy, addr 1 entry_count. Always
//         ready; write only while no request is in flight.
// Flow (accept to rsp beat)
//   An alloc walks the size memory one entry per cycle through a single
//   comparator. req.ready stays low meanwhile; one request is in flight
//   at a time, the next one is taken with the rsp beat.
// Stalls
//   rsp has an output register: the next request is taken while a
//   response waits. A finished scan holds in the engine until the
//   register frees up.
// Reset
//   rst clears all taken marks, both registers and the handshakes. Sizes
//   are not cleared; every scanned entry must be loaded first.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit (
  input wire        clk,
  input wire        rst,
  fpba_req_if.sink  req,
  fpba_rsp_if.source rsp,
  fpba_cfg_if.sink  cfg
);
  import fpba_pkg::*;

  logic [POL_W-1:0] fit_policy;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] limit;

  fpba_ctl_t  ctl;
  fpba_stat_t stat;
  fpba_req_t  req_beat;
  fpba_res_t  res;

  // config registers; unknown addresses are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POL_FIRST;
      entry_count <= '0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_FIT_POLICY:  fit_policy  <= cfg.data[POL_W-1:0];
        REG_ENTRY_COUNT: entry_count <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // count beyond the table saturates
  assign limit = (entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                     : entry_count;

  assign req.ready = stat.idle;

  always_comb begin
    req_beat.cmd           = req.cmd;
    req_beat.entry_index   = req.entry_index;
    req_beat.entry_size    = req.entry_size;
    req_beat.request_size  = req.request_size;
    req_beat.final_request = req.final_request;
    ctl.start              = req.valid && req.ready;
    ctl.res_ready          = !rsp.valid || rsp.ready;
  end

  fpba_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req    (req_beat),
    .policy (fit_policy),
    .limit  (limit),
    .stat   (stat),
    .res    (res)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (stat.res_valid && ctl.res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && ctl.res_ready) begin
      rsp.granted      <= res.granted;
      rsp.chosen_index <= res.chosen_index;
      rsp.batch_end    <= res.batch_end;
    end
  end

endmodule

`default_nettype wire

@@ sv/fpba_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpba_checker: port-level checks of the partition allocator
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module fpba_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        req_valid,
  input wire                        req_ready,
  input wire                        rsp_valid,
  input wire                        rsp_ready,
  input wire                        rsp_granted,
  input wire [fpba_pkg::IDX_W-1:0]  rsp_chosen_index,
  input wire                        rsp_batch_end
);
  import fpba_pkg::*;

  // one request in flight: ready drops straight after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one in flight");

  // no grant means index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_granted |-> rsp_chosen_index == '0)
    else $error("index set without a grant");

  // reset empties the response register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted) &&
      $stable(rsp_chosen_index) && $stable(rsp_batch_end))
    else $error("stalled response changed");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_granted      (rsp.granted),
  .rsp_chosen_index (rsp.chosen_index),
  .rsp_batch_end    (rsp.batch_end)
);

`default_nettype wire
